// ----- sv/iprc_pkg.sv -----
package iprc_pkg;

  localparam int unsigned Rules        = 512;
  localparam int unsigned PortsPerRule = 16;
  localparam int unsigned Services     = 1024;

  localparam int unsigned RuleW  = $clog2(Rules);
  localparam int unsigned SlotW  = $clog2(PortsPerRule);
  localparam int unsigned SvcW   = $clog2(Services);
  localparam int unsigned PortAW = RuleW + SlotW;
  localparam int unsigned CntW   = $clog2(PortsPerRule + 1);

  localparam logic [1:0] FuncByte    = 2'd0;
  localparam logic [1:0] FuncPort    = 2'd1;
  localparam logic [1:0] FuncRuleHdr = 2'd2;
  localparam logic [1:0] FuncService = 2'd3;

  localparam logic [2:0] VerdictPass    = 3'd0;
  localparam logic [2:0] VerdictNoRule  = 3'd1;
  localparam logic [2:0] VerdictNoSvc   = 3'd2;
  localparam logic [2:0] VerdictAuth    = 3'd3;
  localparam logic [2:0] VerdictForward = 3'd4;

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoIcmp = 8'd1;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [6:0]  PosMax    = 7'd127;

  // controller -> datapath
  typedef struct packed {
    logic start;      // begin rule scan, clear frame parse state
    logic load_hdr;   // issue read of rule header at scan rule
    logic next_slot;  // advance port slot
    logic next_rule;  // advance to the next rule
    logic svc_read;   // read service table for matched rule
    logic emit;       // result register load
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic clearing;   // table clearing pass after reset
    logic unparsed;   // frame not classifiable
    logic rule_ok;    // current rule present with protocol hit
    logic slot_hit;   // current port slot matches
    logic slot_end;   // no more slots in this rule
    logic rule_last;  // scan is on the final rule
  } sts_t;

endpackage

// ----- sv/iprc_ctrl.sv -----
module iprc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           frame_end_i,
  input  logic           out_free_i,
  input  iprc_pkg::sts_t sts_i,
  output iprc_pkg::ctl_t ctl_o,
  output logic           busy_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StHdr  = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StSlot = 3'd3;
  localparam logic [2:0] StSvc  = 3'd4;
  localparam logic [2:0] StEmit = 3'd5;
  localparam logic [2:0] StCap  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       hit_q, hit_d;

  always_comb begin
    state_d = state_q;
    hit_d   = hit_q;
    ctl_o   = '0;
    case (state_q)
      StIdle: begin
        if (frame_end_i) begin
          hit_d   = 1'b0;
          state_d = StCap;
        end
      end
      // final byte is in the parse state now
      StCap: begin
        ctl_o.start = 1'b1;
        state_d     = StHdr;
      end
      StHdr: begin
        if (sts_i.unparsed) begin
          state_d = StEmit;
        end else begin
          ctl_o.load_hdr = 1'b1;
          state_d        = StChk;
        end
      end
      StChk: begin
        if (sts_i.rule_ok) begin
          state_d = StSlot;
        end else if (sts_i.rule_last) begin
          state_d = StEmit;
        end else begin
          ctl_o.next_rule = 1'b1;
          state_d         = StHdr;
        end
      end
      StSlot: begin
        if (sts_i.slot_end) begin
          if (sts_i.rule_last) begin
            state_d = StEmit;
          end else begin
            ctl_o.next_rule = 1'b1;
            state_d         = StHdr;
          end
        end else if (sts_i.slot_hit) begin
          hit_d          = 1'b1;
          ctl_o.svc_read = 1'b1;
          state_d        = StSvc;
        end else begin
          ctl_o.next_slot = 1'b1;
        end
      end
      StSvc: state_d = StEmit;
      StEmit: begin
        if (out_free_i) begin
          ctl_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle) || sts_i.clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hit_q   <= hit_d;
    end
  end

  a_emit_from_emit_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.emit |-> state_q == StEmit)
    else $error("emit outside emit state");
  a_start_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.start |=> state_q == StHdr)
    else $error("scan did not start");
  a_svc_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSvc |-> hit_q)
    else $error("service read without port hit");

endmodule

// ----- sv/iprc_datapath.sv -----
module iprc_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_beat_i,
  input  logic [1:0]     func_i,
  input  logic [7:0]     data_byte_i,
  input  logic [8:0]     rule_index_i,
  input  logic [3:0]     port_slot_i,
  input  logic [15:0]    port_value_i,
  input  logic           entry_valid_i,
  input  logic [2:0]     protocol_mask_i,
  input  logic           auth_flag_i,
  input  logic [4:0]     slot_total_i,
  input  logic           dest_present_i,
  input  logic [9:0]     svc_sel_i,
  input  iprc_pkg::ctl_t ctl_i,
  output iprc_pkg::sts_t sts_o,
  output logic [2:0]     verdict_o,
  output logic           pass_o,
  output logic [8:0]     rule_o,
  output logic [9:0]     svc_o
);

  localparam int unsigned HdrW = 1 + 3 + 1 + iprc_pkg::CntW + 1 + iprc_pkg::SvcW;

  // frame parse
  logic [6:0]  pos_q;
  logic [15:0] etype_q;
  logic [3:0]  ihl_q, ver_q;
  logic [7:0]  proto_q;
  logic [15:0] dport_q;
  logic [7:0]  tpos;
  logic        byte_beat;

  assign byte_beat = in_beat_i && (func_i == iprc_pkg::FuncByte);

  always_comb begin
    if (pos_q == 7'd14) tpos = 8'd14 + {2'd0, data_byte_i[3:0], 2'b00};
    else                tpos = 8'd14 + {2'd0, ihl_q, 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; etype_q <= '0; ihl_q <= '0; ver_q <= '0; proto_q <= '0; dport_q <= '0;
    end else if (ctl_i.start) begin
      pos_q <= '0; etype_q <= '0; ihl_q <= '0; ver_q <= '0; proto_q <= '0; dport_q <= '0;
    end else if (byte_beat) begin
      if (pos_q == 7'd12) etype_q[15:8] <= data_byte_i;
      if (pos_q == 7'd13) etype_q[7:0] <= data_byte_i;
      if (pos_q == 7'd14) begin
        ver_q <= data_byte_i[7:4];
        ihl_q <= data_byte_i[3:0];
      end
      if (pos_q == 7'd23) proto_q <= data_byte_i;
      if (pos_q > 7'd14 && {1'b0, pos_q} == tpos + 8'd2) dport_q[15:8] <= data_byte_i;
      if (pos_q > 7'd14 && {1'b0, pos_q} == tpos + 8'd3) dport_q[7:0] <= data_byte_i;
      if (pos_q < iprc_pkg::PosMax) pos_q <= pos_q + 7'd1;
    end
  end

  // classify summary, captured at scan start
  logic [7:0]  n_len, t_len;
  logic        unparsed_c;
  logic [2:0]  pmask_c;
  logic [15:0] port_c;
  logic        unparsed_q;
  logic [2:0]  pmask_q;
  logic [15:0] port_q;

  assign n_len = {1'b0, pos_q};
  assign t_len = 8'd14 + {2'd0, ihl_q, 2'b00};

  always_comb begin
    unparsed_c = 1'b0;
    pmask_c    = 3'b000;
    port_c     = '0;
    if (n_len < 8'd14 || etype_q != iprc_pkg::EtypeIpv4 || n_len < 8'd34 ||
        ver_q != 4'd4 || ihl_q < 4'd5) begin
      unparsed_c = 1'b1;
    end else if (proto_q == iprc_pkg::ProtoTcp) begin
      unparsed_c = ({1'b0, n_len} < {1'b0, t_len} + 9'd20);
      pmask_c    = 3'b001;
      port_c     = dport_q;
    end else if (proto_q == iprc_pkg::ProtoUdp) begin
      unparsed_c = ({1'b0, n_len} < {1'b0, t_len} + 9'd8);
      pmask_c    = 3'b010;
      port_c     = dport_q;
    end else if (proto_q == iprc_pkg::ProtoIcmp) begin
      pmask_c = 3'b100;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) unparsed_q <= 1'b0;
    else if (ctl_i.start) unparsed_q <= unparsed_c;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      pmask_q <= pmask_c;
      port_q  <= port_c;
    end
  end

  // tables; present bits live in the memories and are cleared by a pass after reset
  logic [HdrW-1:0]             hdr_mem [iprc_pkg::Rules];
  logic [15:0]                 port_mem [iprc_pkg::Rules * iprc_pkg::PortsPerRule];
  logic [1:0]                  svc_mem [iprc_pkg::Services];  // {present, auth}

  logic                        clr_q;
  logic [iprc_pkg::SvcW-1:0]   clr_idx_q;
  logic [iprc_pkg::RuleW-1:0]  rule_q;
  logic [iprc_pkg::CntW-1:0]   slot_q;
  logic [HdrW-1:0]             hdr_rd_q;
  logic [15:0]                 port_rd_q;
  logic [1:0]                  svc_rd_q;
  logic [iprc_pkg::CntW-1:0]   cnt_clamp;
  logic [iprc_pkg::PortAW-1:0] port_rd_addr;

  assign cnt_clamp = (slot_total_i > 5'(iprc_pkg::PortsPerRule)) ?
                     iprc_pkg::CntW'(iprc_pkg::PortsPerRule) :
                     iprc_pkg::CntW'(slot_total_i);

  // one entry of the rule header and service tables per cycle, services set the length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == iprc_pkg::SvcW'(iprc_pkg::Services - 1)) clr_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      hdr_mem[clr_idx_q[iprc_pkg::RuleW-1:0]] <= '0;
      svc_mem[clr_idx_q] <= '0;
    end else if (in_beat_i) begin
      if (func_i == iprc_pkg::FuncRuleHdr)
        hdr_mem[rule_index_i] <= {entry_valid_i, protocol_mask_i, auth_flag_i, cnt_clamp,
                                  dest_present_i, svc_sel_i};
      if (func_i == iprc_pkg::FuncPort)
        port_mem[{rule_index_i, port_slot_i}] <= port_value_i;
      if (func_i == iprc_pkg::FuncService)
        svc_mem[svc_sel_i] <= {entry_valid_i, auth_flag_i};
    end
  end

  logic                      h_vld;
  logic [2:0]                h_prot;
  logic                      h_auth;
  logic [iprc_pkg::CntW-1:0] h_cnt;
  logic                      h_dest;
  logic [iprc_pkg::SvcW-1:0] h_sid;

  assign {h_vld, h_prot, h_auth, h_cnt, h_dest, h_sid} = hdr_rd_q;

  // next slot address, read one slot ahead
  logic [iprc_pkg::CntW-1:0] slot_nx;
  always_comb begin
    if (ctl_i.load_hdr)       slot_nx = '0;
    else if (ctl_i.next_slot) slot_nx = slot_q + 1'b1;
    else                      slot_nx = slot_q;
  end
  assign port_rd_addr = {rule_q, slot_nx[iprc_pkg::SlotW-1:0]};

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_hdr) hdr_rd_q <= hdr_mem[rule_q];
    port_rd_q <= port_mem[port_rd_addr];
    if (ctl_i.svc_read) svc_rd_q <= svc_mem[h_sid];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q <= '0;
      slot_q <= '0;
    end else begin
      if (ctl_i.start)          rule_q <= '0;
      else if (ctl_i.next_rule) rule_q <= rule_q + 1'b1;
      slot_q <= slot_nx;
    end
  end

  assign sts_o.clearing  = clr_q;
  assign sts_o.unparsed  = unparsed_q;
  assign sts_o.rule_ok   = h_vld && ((h_prot & pmask_q) != 3'b000);
  assign sts_o.slot_hit  = (port_rd_q == port_q);
  assign sts_o.slot_end  = (slot_q >= h_cnt);
  assign sts_o.rule_last = (rule_q == iprc_pkg::RuleW'(iprc_pkg::Rules - 1));

  // verdict, valid in the emit state
  logic found_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) found_q <= 1'b0;
    else if (ctl_i.start) found_q <= 1'b0;
    else if (ctl_i.svc_read) found_q <= 1'b1;
  end

  always_comb begin
    verdict_o = iprc_pkg::VerdictPass;
    rule_o    = '0;
    svc_o     = '0;
    if (!unparsed_q) begin
      if (!found_q) begin
        verdict_o = iprc_pkg::VerdictNoRule;
      end else begin
        rule_o = 9'(rule_q);
        if (!(h_dest && svc_rd_q[1])) begin
          verdict_o = iprc_pkg::VerdictNoSvc;
        end else begin
          svc_o     = 10'(h_sid);
          verdict_o = (h_auth || svc_rd_q[0]) ? iprc_pkg::VerdictAuth :
                      iprc_pkg::VerdictForward;
        end
      end
    end
    pass_o = !(verdict_o == iprc_pkg::VerdictNoRule || verdict_o == iprc_pkg::VerdictNoSvc);
  end

  a_pos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> pos_q == 7'd0)
    else $error("parse state not cleared");
  a_rule_holds_on_svc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.svc_read |=> $stable(rule_q))
    else $error("rule index moved after hit");
  a_unparsed_no_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unparsed_q && !ctl_i.start |-> !found_q)
    else $error("unparsed frame matched a rule");

endmodule

// ----- sv/ipv4_port_rule_classifier_top.sv -----
// ipv4 port rule classifier. each input beat is a frame byte or a table write
// (rule port slot, rule header, service), selected by tuser. after reset a clearing
// pass empties the rule and service tables with input held off. table writes and
// non-final bytes do not hold input off. a frame's final byte starts a scan of the
// rule table (none if unparsed): a capture step, then per rule a header read and
// check and, if it passes, its port slots one by one up to a hit or the list end;
// a hit reads the service table and ends the scan. the rule and port memories have
// a single read port each. input is held off through the scan and any wait for the
// output. one result beat per frame leaves through an output register.
module ipv4_port_rule_classifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // data_byte[7:0], rule_index[16:8], port_slot[20:17], port_value[36:21],
  // entry_valid[37], protocol_mask[40:38], auth_flag[41], slot_total[46:42],
  // dest_present[47], svc_sel[57:48], zero fill to 64
  input  logic [63:0] s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,  // func
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // verdict[2:0], pass_packet[3], matched_rule[12:4], dst_svc[22:13], zero fill
  output logic [23:0] m_axis_tdata_o
);

  iprc_pkg::ctl_t ctl;
  iprc_pkg::sts_t sts;
  logic           busy;
  logic           in_beat;
  logic           frame_end;
  logic [2:0]     verdict;
  logic           pass;
  logic [8:0]     rule;
  logic [9:0]     svc;
  logic           ovld_q;
  logic [22:0]    odata_q;

  // no input while a scan or the clearing pass runs
  assign s_axis_tready_o = !busy;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign frame_end       = in_beat && (s_axis_tuser_i == iprc_pkg::FuncByte) &&
                           s_axis_tlast_i;

  iprc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_end_i (frame_end),
    .out_free_i  (!ovld_q || m_axis_tready_i),
    .sts_i       (sts),
    .ctl_o       (ctl),
    .busy_o      (busy)
  );

  iprc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_beat_i       (in_beat),
    .func_i          (s_axis_tuser_i),
    .data_byte_i     (s_axis_tdata_i[7:0]),
    .rule_index_i    (s_axis_tdata_i[16:8]),
    .port_slot_i     (s_axis_tdata_i[20:17]),
    .port_value_i    (s_axis_tdata_i[36:21]),
    .entry_valid_i   (s_axis_tdata_i[37]),
    .protocol_mask_i (s_axis_tdata_i[40:38]),
    .auth_flag_i     (s_axis_tdata_i[41]),
    .slot_total_i    (s_axis_tdata_i[46:42]),
    .dest_present_i  (s_axis_tdata_i[47]),
    .svc_sel_i       (s_axis_tdata_i[57:48]),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .verdict_o       (verdict),
    .pass_o          (pass),
    .rule_o          (rule),
    .svc_o           (svc)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (ctl.emit) begin
      ovld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit) odata_q <= {svc, rule, pass, verdict};
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = {1'b0, odata_q};

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |-> !ovld_q || m_axis_tready_i)
    else $error("result overwritten");
  a_no_input_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready_o)
    else $error("input taken during scan");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !m_axis_tready_i |=> ovld_q && $stable(odata_q))
    else $error("result beat changed while stalled");

endmodule

// ----- test/ipv4_port_rule_classifier_top_test.sv -----
module ipv4_port_rule_classifier_top_test;
  import iprc_pkg::*;

  // tdata layout of an input beat, lowest field last
  typedef struct packed {
    logic [5:0]  fill;
    logic [9:0]  svc_id;
    logic        dest_present;
    logic [4:0]  slot_total;
    logic        auth;
    logic [2:0]  prot_mask;
    logic        entry_valid;
    logic [15:0] port_value;
    logic [3:0]  port_slot;
    logic [8:0]  rule_index;
    logic [7:0]  data_byte;
  } in_fields_t;

  typedef struct {
    logic [1:0]  func;
    in_fields_t  fields;
    logic        last;
    bit          drain;   // marker: sender waits until every verdict is back
  } beat_t;

  // tdata layout of a verdict beat
  typedef struct packed {
    logic [9:0] dst_svc;
    logic [8:0] matched_rule;
    logic       pass_packet;
    logic [2:0] verdict;
  } verdict_t;

  typedef enum int {
    FrTcp, FrUdp, FrIcmp, FrOther, FrShort, FrNotIp, FrIpShort,
    FrBadVer, FrBadIhl, FrTrunc, FrLong
  } frame_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = FuncByte;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  ipv4_port_rule_classifier_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  beat_t    beat_q[$];      // beats waiting to be offered
  verdict_t verdict_q[$];   // verdicts predicted, not yet seen
  int       mismatches = 0;
  int       verdicts_seen = 0;

  // predictor copy of the parse state
  int          pr_pos = 0;
  logic [15:0] pr_etype = '0;
  logic [3:0]  pr_ihl = '0;
  logic [3:0]  pr_ver = '0;
  logic [7:0]  pr_proto = '0;
  logic [15:0] pr_dport = '0;

  // predictor copy of the tables
  bit          rl_present[Rules];
  logic [2:0]  rl_mask[Rules];
  bit          rl_auth[Rules];
  int          rl_cnt[Rules];
  bit          rl_has_dst[Rules];
  logic [9:0]  rl_dst[Rules];
  logic [15:0] rl_ports[Rules][PortsPerRule];
  bit          sv_present[Services];
  bit          sv_auth[Services];

  // generator-side record of written port slots, so no rule covers an unwritten one
  bit          slot_written[Rules][PortsPerRule];

  function automatic verdict_t classify_frame();
    verdict_t    v;
    int          t;
    logic [2:0]  want;
    logic [15:0] port;
    int          r;
    bit          hit;
    logic [9:0]  s;
    v = '0;
    v.pass_packet = 1'b1;
    t = 14 + 4 * pr_ihl;
    want = 3'b000;
    port = 16'd0;
    hit = 1'b0;
    if (pr_pos < 14 || pr_etype != EtypeIpv4 || pr_pos < 34) return v;
    if (pr_ver != 4'd4 || pr_ihl < 4'd5) return v;
    if (pr_proto == ProtoTcp) begin
      if (pr_pos < t + 20) return v;
      want = 3'b001;
      port = pr_dport;
    end else if (pr_proto == ProtoUdp) begin
      if (pr_pos < t + 8) return v;
      want = 3'b010;
      port = pr_dport;
    end else if (pr_proto == ProtoIcmp) begin
      want = 3'b100;
    end
    // first present rule with protocol hit and port in its list
    for (r = 0; r < Rules && !hit; r++) begin
      if (rl_present[r] && (rl_mask[r] & want) != 3'b000) begin
        for (int i = 0; i < rl_cnt[r]; i++)
          if (rl_ports[r][i] == port) hit = 1'b1;
      end
      if (hit) break;
    end
    if (!hit) begin
      v.verdict = VerdictNoRule;
      v.pass_packet = 1'b0;
      return v;
    end
    v.matched_rule = r[8:0];
    s = rl_dst[r];
    if (!rl_has_dst[r] || !sv_present[s]) begin
      v.verdict = VerdictNoSvc;
      v.pass_packet = 1'b0;
      return v;
    end
    v.dst_svc = s;
    v.verdict = (rl_auth[r] || sv_auth[s]) ? VerdictAuth : VerdictForward;
    return v;
  endfunction

  task automatic track_beat(beat_t bt);
    in_fields_t f;
    int         t;
    f = bt.fields;
    case (bt.func)
      FuncByte: begin
        t = 14 + 4 * pr_ihl;
        if (pr_pos == 12) pr_etype[15:8] = f.data_byte;
        if (pr_pos == 13) pr_etype[7:0] = f.data_byte;
        if (pr_pos == 14) begin
          pr_ver = f.data_byte[7:4];
          pr_ihl = f.data_byte[3:0];
          t = 14 + 4 * pr_ihl;
        end
        if (pr_pos == 23) pr_proto = f.data_byte;
        if (pr_pos > 14 && pr_pos == t + 2) pr_dport[15:8] = f.data_byte;
        if (pr_pos > 14 && pr_pos == t + 3) pr_dport[7:0] = f.data_byte;
        if (pr_pos < PosMax) pr_pos++;
        if (bt.last) begin
          verdict_q.push_back(classify_frame());
          pr_pos = 0;
          pr_etype = '0;
          pr_ihl = '0;
          pr_ver = '0;
          pr_proto = '0;
          pr_dport = '0;
        end
      end
      FuncPort: rl_ports[f.rule_index][f.port_slot] = f.port_value;
      FuncRuleHdr: begin
        rl_present[f.rule_index] = f.entry_valid;
        rl_mask[f.rule_index]    = f.prot_mask;
        rl_auth[f.rule_index]    = f.auth;
        rl_cnt[f.rule_index]     = (f.slot_total > PortsPerRule) ? PortsPerRule
                                                                 : f.slot_total;
        rl_has_dst[f.rule_index] = f.dest_present;
        rl_dst[f.rule_index]     = f.svc_id;
      end
      default: begin
        sv_present[f.svc_id] = f.entry_valid;
        sv_auth[f.svc_id]    = f.auth;
      end
    endcase
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic in_fields_t noise_fields();
    in_fields_t f;
    f = {$urandom, $urandom};
    f.fill = '0;
    return f;
  endfunction

  function automatic logic [8:0] pick_rule();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 9'($urandom_range(0, 15));
    if (r < 8) return 9'($urandom_range(500, 511));
    return 9'($urandom);
  endfunction

  function automatic logic [9:0] pick_service();
    return ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 7))
                                       : 10'($urandom_range(1016, 1023));
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd80;
      2: return 16'd443;
      3: return 16'd53;
      4: return 16'hFFFF;
      5: return 16'd22;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_write(logic [1:0] func, in_fields_t f);
    beat_t bt;
    bt.func = func;
    bt.fields = f;
    bt.last = 1'($urandom);
    bt.drain = 1'b0;
    beat_q.push_back(bt);
  endtask

  task automatic write_port(logic [8:0] rix, logic [3:0] slot, logic [15:0] pv);
    in_fields_t f;
    f = noise_fields();
    f.rule_index = rix;
    f.port_slot = slot;
    f.port_value = pv;
    slot_written[rix][slot] = 1'b1;
    push_write(FuncPort, f);
  endtask

  // any slot the count covers gets a port first
  task automatic write_rule(logic [8:0] rix, bit valid, logic [2:0] mask, bit auth,
                            logic [4:0] cnt, bit has_dst, logic [9:0] sid);
    in_fields_t f;
    int         n;
    n = (cnt > PortsPerRule) ? PortsPerRule : cnt;
    for (int i = 0; i < n; i++)
      if (!slot_written[rix][i]) write_port(rix, 4'(i), pick_port());
    f = noise_fields();
    f.rule_index = rix;
    f.entry_valid = valid;
    f.prot_mask = mask;
    f.auth = auth;
    f.slot_total = cnt;
    f.dest_present = has_dst;
    f.svc_id = sid;
    push_write(FuncRuleHdr, f);
  endtask

  task automatic write_service(logic [9:0] sid, bit valid, bit auth);
    in_fields_t f;
    f = noise_fields();
    f.svc_id = sid;
    f.entry_valid = valid;
    f.auth = auth;
    push_write(FuncService, f);
  endtask

  task automatic push_frame(frame_kind_e kind, logic [15:0] port);
    logic [7:0] fb[];
    int         len;
    int         ihl;
    int         t;
    logic [7:0] proto;
    beat_t      bt;
    ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
    t = 14 + 4 * ihl;
    proto = ProtoTcp;
    case (kind)
      FrTcp:     len = t + 20 + $urandom_range(0, 12);
      FrUdp:     begin proto = ProtoUdp; len = t + 8 + $urandom_range(0, 12); end
      FrIcmp:    begin proto = ProtoIcmp; len = t + $urandom_range(0, 12); end
      FrOther:   begin
        proto = 8'($urandom);
        if (proto == ProtoTcp || proto == ProtoUdp || proto == ProtoIcmp) proto = 8'd47;
        len = t + $urandom_range(0, 12);
      end
      FrShort:   len = $urandom_range(1, 13);
      FrNotIp:   len = $urandom_range(14, 60);
      FrIpShort: len = $urandom_range(14, 33);
      FrBadVer:  len = $urandom_range(34, 70);
      FrBadIhl:  begin ihl = $urandom_range(0, 4); len = $urandom_range(34, 70); end
      FrTrunc:   begin
        ihl = 5;
        t = 34;
        if ($urandom_range(0, 1) == 0) len = $urandom_range(38, t + 19);
        else begin proto = ProtoUdp; len = $urandom_range(34, t + 7); end
      end
      default:   len = $urandom_range(128, 160);
    endcase
    if (len < 34 && kind inside {FrTcp, FrUdp, FrIcmp, FrOther}) len = 34;
    fb = new[len];
    foreach (fb[i]) fb[i] = 8'($urandom);
    if (len > 13) begin
      fb[12] = EtypeIpv4[15:8];
      fb[13] = EtypeIpv4[7:0];
      if (kind == FrNotIp) fb[13] = 8'($urandom_range(0, 255)) | 8'h01;
    end
    if (len > 14) begin
      fb[14] = {4'd4, 4'(ihl)};
      if (kind == FrBadVer) fb[14][7:4] = ($urandom_range(0, 1) == 0) ? 4'd6
                                                                      : 4'($urandom);
      if (kind == FrBadVer && fb[14][7:4] == 4'd4) fb[14][7:4] = 4'd15;
    end
    if (len > 23) fb[23] = proto;
    if (kind != FrBadIhl && len > t + 3) begin
      fb[t + 2] = port[15:8];
      fb[t + 3] = port[7:0];
    end
    foreach (fb[i]) begin
      bt.func = FuncByte;
      bt.fields = noise_fields();
      bt.fields.data_byte = fb[i];
      bt.last = (i == len - 1);
      bt.drain = 1'b0;
      beat_q.push_back(bt);
    end
  endtask

  task automatic push_drain();
    beat_t bt;
    bt.func = FuncByte;
    bt.fields = '0;
    bt.last = 1'b0;
    bt.drain = 1'b1;
    beat_q.push_back(bt);
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------- driver ----------------

  int send_gap = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      beat_t cur;
      cur.func = s_tuser;
      cur.fields = s_tdata;
      cur.last = s_tlast;
      cur.drain = 1'b0;
      if (s_tvalid && s_tready) track_beat(cur);
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (beat_q.size() > 0 && beat_q[0].drain) begin
          s_tvalid <= 1'b0;
          if (verdict_q.size() == 0 && !(s_tvalid && s_tready && s_tlast)) begin
            void'(beat_q.pop_front());
          end
        end else if (beat_q.size() > 0) begin
          cur = beat_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= cur.func;
          s_tdata  <= cur.fields;
          s_tlast  <= cur.last;
          send_gap <= pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  int  hold_left = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      verdict_t got;
      verdict_t want;
      got = m_tdata[22:0];
      if (m_tvalid && m_tready) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict beat with nothing expected: %h", m_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (got.verdict != want.verdict || got.pass_packet != want.pass_packet ||
              got.matched_rule != want.matched_rule ||
              got.dst_svc != want.dst_svc) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"verdict mismatch: exp v=%0d pass=%0d rule=%0d svc=%0d, ",
                        "got v=%0d pass=%0d rule=%0d svc=%0d"},
                       want.verdict, want.pass_packet, want.matched_rule,
                       want.dst_svc, got.verdict, got.pass_packet,
                       got.matched_rule, got.dst_svc);
          end
        end
      end
      // one long back-pressure stretch while the sender keeps offering
      if (!long_hold_done && verdicts_seen == 12) begin
        long_hold_done <= 1'b1;
        hold_left <= 400;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (pick_gap() == 0);
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    int n_items;
    int n_frames;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: table extremes, every func, every verdict and malformed case
    write_service(10'd1023, 1'b1, 1'b0);
    write_service(10'd5, 1'b1, 1'b1);
    write_service(10'd0, 1'b0, 1'b1);
    write_port(9'd0, 4'd0, 16'd80);
    write_rule(9'd0, 1'b1, 3'b001, 1'b0, 5'd1, 1'b1, 10'd1023);
    write_port(9'd511, 4'd15, 16'hFFFF);
    write_rule(9'd511, 1'b1, 3'b111, 1'b0, 5'd31, 1'b1, 10'd5);
    write_port(9'd3, 4'd0, 16'd0);
    write_rule(9'd3, 1'b1, 3'b100, 1'b1, 5'd16, 1'b0, 10'd0);
    push_frame(FrTcp, 16'd80);       // forward via rule 0
    push_frame(FrUdp, 16'hFFFF);     // rule 511, auth service: auth verdict
    push_frame(FrUdp, 16'd1234);     // no rule
    push_frame(FrIcmp, 16'd0);       // rule 3 has no destination
    push_frame(FrOther, 16'd80);
    push_frame(FrShort, 16'd0);
    push_frame(FrNotIp, 16'd80);
    push_frame(FrIpShort, 16'd80);
    push_frame(FrBadVer, 16'd80);
    push_frame(FrBadIhl, 16'd80);
    push_frame(FrTrunc, 16'd80);
    push_frame(FrLong, 16'd80);
    push_drain();

    // random: mostly well-formed frames against a churning rule table
    n_items = beat_q.size();
    n_frames = 0;
    while (n_items < 1600) begin
      int r;
      int before_sz;
      before_sz = beat_q.size();
      r = $urandom_range(0, 99);
      if (r < 12) write_port(pick_rule(), 4'($urandom), pick_port());
      else if (r < 22)
        write_rule(pick_rule(), ($urandom_range(0, 3) != 0), 3'($urandom), 1'($urandom),
                   5'($urandom), ($urandom_range(0, 4) != 0), pick_service());
      else if (r < 28) write_service(pick_service(), ($urandom_range(0, 3) != 0),
                                     1'($urandom));
      else begin
        r = $urandom_range(0, 99);
        n_frames++;
        if (r < 30) push_frame(FrTcp, pick_port());
        else if (r < 55) push_frame(FrUdp, pick_port());
        else if (r < 65) push_frame(FrIcmp, pick_port());
        else if (r < 70) push_frame(FrOther, pick_port());
        else if (r < 74) push_frame(FrShort, pick_port());
        else if (r < 78) push_frame(FrNotIp, pick_port());
        else if (r < 82) push_frame(FrIpShort, pick_port());
        else if (r < 86) push_frame(FrBadVer, pick_port());
        else if (r < 90) push_frame(FrBadIhl, pick_port());
        else if (r < 97) push_frame(FrTrunc, pick_port());
        else push_frame(FrLong, pick_port());
        if (n_frames == 10) push_drain();
      end
      n_items += beat_q.size() - before_sz;
    end

    while (beat_q.size() > 0 || s_tvalid || verdict_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("ipv4_port_rule_classifier_top_test passed");
    end else begin
      $display("ipv4_port_rule_classifier_top_test failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("ipv4_port_rule_classifier_top_test failed");
    $finish;
  end

endmodule
